// ===== hdl/idll_pkg.sv =====
package idll_pkg;

    // default pool geometry
    localparam int CAPACITY_DEF   = 256;
    localparam int DATA_WIDTH_DEF = 32;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;

    // memory enables from the sequencer to the link store
    typedef struct packed {
        logic rd_en;
        logic nx_we;
        logic pv_we;
        logic pl_we;
    } idll_mem_ctl_t;

    // one result word
    typedef struct packed {
        logic [7:0] slot;
        logic [1:0] status;
        logic [7:0] count;
        logic [7:0] head_slot;
        logic [7:0] tail_slot;
    } idll_result_t;

endpackage

// ===== hdl/idll_store.sv =====
module idll_store #(
    parameter int CAPACITY   = idll_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = idll_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  idll_pkg::idll_mem_ctl_t       mem_ctl,
    input  logic [$clog2(CAPACITY)-1:0]   rd_addr0,
    input  logic [$clog2(CAPACITY)-1:0]   rd_addr1,
    input  logic [$clog2(CAPACITY)-1:0]   nx_waddr,
    input  logic [$clog2(CAPACITY):0]     nx_wdata,
    input  logic [$clog2(CAPACITY)-1:0]   pv_waddr,
    input  logic [$clog2(CAPACITY)-1:0]   pv_wdata,
    input  logic [DATA_WIDTH-1:0]         pl_wdata,
    output logic [$clog2(CAPACITY):0]     nx_rd0,
    output logic [$clog2(CAPACITY):0]     nx_rd1,
    output logic [$clog2(CAPACITY)-1:0]   pv_rd
);

    localparam int IDX_W = $clog2(CAPACITY);

    // next memory entry: in-use flag on top, next link below
    logic [IDX_W:0]      next_mem [CAPACITY];
    logic [IDX_W-1:0]    prev_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] payload_mem [CAPACITY];

    logic [IDX_W:0]      nx_rd0_reg;
    logic [IDX_W:0]      nx_rd1_reg;
    logic [IDX_W-1:0]    pv_rd_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.nx_we)
        begin
            next_mem[nx_waddr] <= nx_wdata;
        end
        if (mem_ctl.rd_en)
        begin
            nx_rd0_reg <= next_mem[rd_addr0];
            nx_rd1_reg <= next_mem[rd_addr1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.pv_we)
        begin
            prev_mem[pv_waddr] <= pv_wdata;
        end
        if (mem_ctl.rd_en)
        begin
            pv_rd_reg <= prev_mem[rd_addr1];
        end
    end

    // payload shares the next-memory write address
    always_ff @(posedge clk)
    begin
        if (mem_ctl.pl_we)
        begin
            payload_mem[nx_waddr] <= pl_wdata;
        end
    end

    assign nx_rd0 = nx_rd0_reg;
    assign nx_rd1 = nx_rd1_reg;
    assign pv_rd  = pv_rd_reg;

endmodule

// ===== hdl/idll_ctrl.sv =====
module idll_ctrl #(
    parameter int CAPACITY   = idll_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = idll_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [1:0]                    command,
    input  logic [7:0]                    position,
    input  logic signed [31:0]            value,
    output logic                          idle,
    input  logic [$clog2(CAPACITY):0]     nx_rd0,
    input  logic [$clog2(CAPACITY):0]     nx_rd1,
    input  logic [$clog2(CAPACITY)-1:0]   pv_rd,
    output idll_pkg::idll_mem_ctl_t       mem_ctl,
    output logic [$clog2(CAPACITY)-1:0]   rd_addr0,
    output logic [$clog2(CAPACITY)-1:0]   rd_addr1,
    output logic [$clog2(CAPACITY)-1:0]   nx_waddr,
    output logic [$clog2(CAPACITY):0]     nx_wdata,
    output logic [$clog2(CAPACITY)-1:0]   pv_waddr,
    output logic [$clog2(CAPACITY)-1:0]   pv_wdata,
    output logic [DATA_WIDTH-1:0]         pl_wdata,
    output logic                          res_valid,
    input  logic                          res_ready,
    output idll_pkg::idll_result_t        result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    typedef enum logic [3:0] {
        S_INIT   = 4'b0001,
        S_IDLE   = 4'b0010,
        S_LOOK   = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  init_idx_reg, init_idx_next;
    logic [IDX_W-1:0]  free_head_reg, free_head_next;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;

    logic [1:0]        cmd_reg, cmd_next;
    logic [IDX_W-1:0]  after_reg, after_next;
    logic [31:0]       value_reg, value_next;
    logic              pre_ok_reg, pre_ok_next;
    logic              need_live_reg, need_live_next;
    logic              ok_reg, ok_next;
    logic [1:0]        status_reg, status_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [IDX_W-1:0]  link_reg, link_next;

    logic              pos_in_range;
    logic              look_ok;

    always_comb
    begin
        state_next     = state_reg;
        init_idx_next  = init_idx_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cmd_next       = cmd_reg;
        after_next     = after_reg;
        value_next     = value_reg;
        pre_ok_next    = pre_ok_reg;
        need_live_next = need_live_reg;
        ok_next        = ok_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        link_next      = link_reg;

        mem_ctl   = '0;
        rd_addr0  = free_head_reg;
        rd_addr1  = IDX_W'(position);
        nx_waddr  = '0;
        nx_wdata  = '0;
        pv_waddr  = '0;
        pv_wdata  = '0;
        pl_wdata  = DATA_WIDTH'(value_reg);
        res_valid = 1'b0;

        pos_in_range = 32'(position) < CAPACITY;
        look_ok      = pre_ok_reg && (!need_live_reg || nx_rd1[IDX_W]);

        unique case (state_reg)
            S_INIT:
            begin
                // build the free chain and self-linked sentinel
                mem_ctl.nx_we = 1'b1;
                mem_ctl.pv_we = 1'b1;
                nx_waddr      = init_idx_reg;
                pv_waddr      = init_idx_reg;
                if (init_idx_reg == '0 || init_idx_reg == LAST_IDX)
                begin
                    nx_wdata = '0;
                end
                else
                begin
                    nx_wdata = {1'b0, init_idx_reg + IDX_W'(1)};
                end
                init_idx_next = init_idx_reg + IDX_W'(1);
                if (init_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mem_ctl.rd_en = 1'b1;
                    cmd_next      = command;
                    value_next    = value;
                    if (command == idll_pkg::CMD_APPEND)
                    begin
                        rd_addr1 = tail_reg;
                    end
                    after_next = rd_addr1;
                    unique case (command)
                        idll_pkg::CMD_INSERT:
                        begin
                            pre_ok_next    = (position == 8'd0) || pos_in_range;
                            need_live_next = position != 8'd0;
                        end
                        idll_pkg::CMD_APPEND:
                        begin
                            pre_ok_next    = 1'b1;
                            need_live_next = 1'b0;
                        end
                        idll_pkg::CMD_DELETE:
                        begin
                            pre_ok_next    = (position != 8'd0) && pos_in_range;
                            need_live_next = 1'b1;
                        end
                        default:
                        begin
                            pre_ok_next    = 1'b0;
                            need_live_next = 1'b0;
                        end
                    endcase
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                ok_next     = 1'b0;
                status_next = idll_pkg::ST_BADPOS;
                if (cmd_reg == idll_pkg::CMD_DELETE)
                begin
                    if (look_ok)
                    begin
                        // unlink: prev.next = next, next.prev = prev
                        ok_next       = 1'b1;
                        status_next   = idll_pkg::ST_OK;
                        slot_next     = after_reg;
                        mem_ctl.nx_we = 1'b1;
                        mem_ctl.pv_we = 1'b1;
                        nx_waddr      = pv_rd;
                        nx_wdata      = {pv_rd != '0, nx_rd1[IDX_W-1:0]};
                        pv_waddr      = nx_rd1[IDX_W-1:0];
                        pv_wdata      = pv_rd;
                        if (pv_rd == '0)
                        begin
                            head_next = nx_rd1[IDX_W-1:0];
                        end
                        if (nx_rd1[IDX_W-1:0] == '0)
                        begin
                            tail_next = pv_rd;
                        end
                    end
                end
                else if (look_ok)
                begin
                    if (free_head_reg == '0)
                    begin
                        status_next = idll_pkg::ST_FULL;
                    end
                    else
                    begin
                        // new slot takes its links and the data word
                        ok_next        = 1'b1;
                        status_next    = idll_pkg::ST_OK;
                        slot_next      = free_head_reg;
                        link_next      = nx_rd1[IDX_W-1:0];
                        free_head_next = nx_rd0[IDX_W-1:0];
                        mem_ctl.nx_we  = 1'b1;
                        mem_ctl.pv_we  = 1'b1;
                        mem_ctl.pl_we  = 1'b1;
                        nx_waddr       = free_head_reg;
                        nx_wdata       = {1'b1, nx_rd1[IDX_W-1:0]};
                        pv_waddr       = free_head_reg;
                        pv_wdata       = after_reg;
                    end
                end
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    if (ok_reg)
                    begin
                        mem_ctl.nx_we = 1'b1;
                        mem_ctl.pv_we = 1'b1;
                        if (cmd_reg == idll_pkg::CMD_DELETE)
                        begin
                            // freed slot goes on the front of the free chain
                            nx_waddr       = slot_reg;
                            nx_wdata       = {1'b0, free_head_reg};
                            pv_waddr       = slot_reg;
                            pv_wdata       = '0;
                            free_head_next = slot_reg;
                            count_next     = count_reg - IDX_W'(1);
                        end
                        else
                        begin
                            // splice between after and its old successor
                            nx_waddr   = after_reg;
                            nx_wdata   = {after_reg != '0, slot_reg};
                            pv_waddr   = link_reg;
                            pv_wdata   = slot_reg;
                            count_next = count_reg + IDX_W'(1);
                            if (after_reg == '0)
                            begin
                                head_next = slot_reg;
                            end
                            if (link_reg == '0)
                            begin
                                tail_next = slot_reg;
                            end
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        result.slot      = ok_reg ? 8'(slot_reg) : 8'd0;
        result.status    = status_reg;
        result.count     = 8'(count_next);
        result.head_slot = 8'(head_next);
        result.tail_slot = 8'(tail_next);
    end

    assign idle = state_reg == S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_idx_reg  <= '0;
            free_head_reg <= IDX_W'(1);
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            init_idx_reg  <= init_idx_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        after_reg     <= after_next;
        value_reg     <= value_next;
        pre_ok_reg    <= pre_ok_next;
        need_live_reg <= need_live_next;
        ok_reg        <= ok_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        link_reg      <= link_next;
    end

endmodule

// ===== hdl/indexed_doubly_linked_list_top.sv =====
// flow: a command word is read in the idle step, checked in the look step, and its
//   result word is loaded into the output register when the commit step hands it over
// one word in flight at a time: the look and commit steps write the link memories
//   after the read step, and the commit step waits until the output register is free
// reset: after rst_n releases, a clearing pass rebuilds the links of every slot;
//   in_stall stays high until it finishes
module indexed_doubly_linked_list_top #(
    parameter int CAPACITY   = idll_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = idll_pkg::DATA_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // command channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [7:0]         position,
    input  logic signed [31:0] value,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         slot,
    output logic [1:0]         status,
    output logic [7:0]         count,
    output logic [7:0]         head_slot,
    output logic [7:0]         tail_slot
);

    localparam int IDX_W = $clog2(CAPACITY);

    // sequencer <-> link store
    idll_pkg::idll_mem_ctl_t mem_ctl;
    logic [IDX_W-1:0]        rd_addr0;
    logic [IDX_W-1:0]        rd_addr1;
    logic [IDX_W-1:0]        nx_waddr;
    logic [IDX_W:0]          nx_wdata;
    logic [IDX_W-1:0]        pv_waddr;
    logic [IDX_W-1:0]        pv_wdata;
    logic [DATA_WIDTH-1:0]   pl_wdata;
    logic [IDX_W:0]          nx_rd0;
    logic [IDX_W:0]          nx_rd1;
    logic [IDX_W-1:0]        pv_rd;

    logic                    idle;
    logic                    res_valid;
    logic                    res_ready;
    idll_pkg::idll_result_t  result;

    // output register
    logic                    out_valid_reg, out_valid_next;
    idll_pkg::idll_result_t  out_word_reg;

    // sequencer: clearing pass, then per word
    //   idle   - accept, read free head and position entries
    //   look   - check, write the first entry of each link memory
    //   commit - write the second entries, hand the result word over
    idll_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .position  (position),
        .value     (value),
        .idle      (idle),
        .nx_rd0    (nx_rd0),
        .nx_rd1    (nx_rd1),
        .pv_rd     (pv_rd),
        .mem_ctl   (mem_ctl),
        .rd_addr0  (rd_addr0),
        .rd_addr1  (rd_addr1),
        .nx_waddr  (nx_waddr),
        .nx_wdata  (nx_wdata),
        .pv_waddr  (pv_waddr),
        .pv_wdata  (pv_wdata),
        .pl_wdata  (pl_wdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (result)
    );

    // next, prev and payload memories; next and prev have registered reads
    idll_store #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk      (clk),
        .mem_ctl  (mem_ctl),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .nx_waddr (nx_waddr),
        .nx_wdata (nx_wdata),
        .pv_waddr (pv_waddr),
        .pv_wdata (pv_wdata),
        .pl_wdata (pl_wdata),
        .nx_rd0   (nx_rd0),
        .nx_rd1   (nx_rd1),
        .pv_rd    (pv_rd)
    );

    // commands are taken only between words and after the clearing pass
    assign in_stall = !idle;

    // the output register frees up the cycle its word is taken, so the
    // sequencer's commit step never waits on a downstream that keeps up
    assign res_ready      = !out_valid_reg || !out_stall;
    assign out_valid_next = (res_valid && res_ready) || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign slot      = out_word_reg.slot;
    assign status    = out_word_reg.status;
    assign count     = out_word_reg.count;
    assign head_slot = out_word_reg.head_slot;
    assign tail_slot = out_word_reg.tail_slot;

`ifndef ASSERT_OFF
    // one command in flight: an accepted word closes the input for the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("command accepted while another is in flight");

    // an error leaves no slot behind
    a_error_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != idll_pkg::ST_OK) |-> slot == 8'd0)
        else $error("error result reports a slot");

    // empty list and sentinel self-links agree
    a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (CAPACITY > 256) ||
                      (((count == 8'd0) == (head_slot == 8'd0)) &&
                       ((count == 8'd0) == (tail_slot == 8'd0))))
        else $error("count disagrees with head or tail");

    // a new result word comes only from the commit step
    a_load_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid ##1 out_valid |-> $past(res_valid))
        else $error("result word appeared without a commit");
`endif

endmodule

// ===== sim/indexed_doubly_linked_list_top_test.sv =====
module indexed_doubly_linked_list_top_test;

    // command code with no operation behind it, answered with a bad-position status
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    // receiver hold-off long enough to back the block up into its input
    localparam int LONG_HOLD    = 300;
    // watchdog: far above the slowest correct run, clearing pass included
    localparam int LIMIT_CYCLES = 400000;

    // shadow of the slot pool: link memories, free chain and element count
    class list_shadow;
        bit [7:0]     nxt  [idll_pkg::CAPACITY_DEF];
        bit [7:0]     prv  [idll_pkg::CAPACITY_DEF];
        bit           used [idll_pkg::CAPACITY_DEF];
        bit [7:0]     free_top;
        bit [7:0]     n_elems;
        idll_pkg::idll_result_t pending [$];
        int           errors;

        function new();
            for (int i = 0; i < idll_pkg::CAPACITY_DEF; i++)
            begin
                nxt[i]  = (i == 0 || i == idll_pkg::CAPACITY_DEF - 1) ? 8'd0 : 8'(i + 1);
                prv[i]  = 8'd0;
                used[i] = 1'b0;
            end
            free_top = 8'd1;
            n_elems  = 8'd0;
            errors   = 0;
        endfunction

        function bit live(bit [7:0] p);
            return p != 8'd0 && used[p];
        endfunction

        // random element slot, 0 when the list is empty
        function bit [7:0] pick_live();
            bit [7:0] p;
            int       steps;
            if (n_elems == 8'd0)
                return 8'd0;
            steps = $urandom_range(0, n_elems - 1);
            p = nxt[0];
            repeat (steps) p = nxt[p];
            return p;
        endfunction

        // pop a slot off the free chain and link it in after the given slot
        function bit [7:0] take_slot(bit [7:0] after, output bit [1:0] st);
            bit [7:0] s;
            bit [7:0] succ;
            s = free_top;
            if (s == 8'd0)
            begin
                st = idll_pkg::ST_FULL;
                return 8'd0;
            end
            free_top = nxt[s];
            succ = nxt[after];
            nxt[s] = succ;
            prv[s] = after;
            nxt[after] = s;
            prv[succ] = s;
            used[s] = 1'b1;
            n_elems++;
            st = idll_pkg::ST_OK;
            return s;
        endfunction

        // apply one accepted command word and queue the result word it causes
        function void note_command(logic [1:0] cmd, logic [7:0] pos);
            idll_pkg::idll_result_t r;
            bit [1:0]     st;
            bit [7:0]     sl;
            bit [7:0]     p_nx;
            bit [7:0]     p_pv;
            st = idll_pkg::ST_BADPOS;
            sl = 8'd0;
            case (cmd)
                idll_pkg::CMD_INSERT:
                    if (pos == 8'd0 || live(pos))
                        sl = take_slot(pos, st);
                idll_pkg::CMD_APPEND:
                    sl = take_slot(prv[0], st);
                idll_pkg::CMD_DELETE:
                    if (live(pos))
                    begin
                        p_nx = nxt[pos];
                        p_pv = prv[pos];
                        nxt[p_pv] = p_nx;
                        prv[p_nx] = p_pv;
                        nxt[pos] = free_top;
                        prv[pos] = 8'd0;
                        free_top = pos;
                        used[pos] = 1'b0;
                        n_elems--;
                        sl = pos;
                        st = idll_pkg::ST_OK;
                    end
                default: ;
            endcase
            r.slot      = sl;
            r.status    = st;
            r.count     = n_elems;
            r.head_slot = nxt[0];
            r.tail_slot = prv[0];
            pending.push_back(r);
        endfunction

        function void field_check(string name, logic [7:0] want_v, logic [7:0] got_v);
            if (got_v !== want_v)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(idll_pkg::idll_result_t got);
            idll_pkg::idll_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, got slot %0d status %0d",
                         $time, got.slot, got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            field_check("slot", want.slot, got.slot);
            field_check("status", 8'(want.status), 8'(got.status));
            field_check("count", want.count, got.count);
            field_check("head_slot", want.head_slot, got.head_slot);
            field_check("tail_slot", want.tail_slot, got.tail_slot);
        endfunction
    endclass

    // clock, reset and block inputs, all known from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [1:0]  command   = 2'd0;
    logic [7:0]  position  = 8'd0;
    logic [31:0] value     = 32'd0;
    logic        out_stall = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [7:0]  slot;
    logic [1:0]  status;
    logic [7:0]  count;
    logic [7:0]  head_slot;
    logic [7:0]  tail_slot;

    list_shadow  shadow = new();

    // handshake between stimulus and receiver
    bit          quiet        = 1'b0;   // last part of the run: no idling on either side
    bit          hold_request = 1'b0;   // ask the receiver for one long hold-off
    int unsigned cycle_count  = 0;

    indexed_doubly_linked_list_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .position  (position),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .slot      (slot),
        .status    (status),
        .count     (count),
        .head_slot (head_slot),
        .tail_slot (tail_slot)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: check each accepted word, then pick the stall for the next cycle;
    // outputs read right after the edge still hold their pre-edge values
    initial
    begin
        idll_pkg::idll_result_t seen;
        int           burst_left;
        burst_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                seen.slot      = slot;
                seen.status    = status;
                seen.count     = count;
                seen.head_slot = head_slot;
                seen.tail_slot = tail_slot;
                shadow.check_result(seen);
            end
            // long hold-off wins over the random bursts
            if (hold_request)
            begin
                hold_request = 1'b0;
                burst_left = LONG_HOLD;
            end
            else if (burst_left == 0 && !quiet && $urandom_range(0, 7) == 0)
                burst_left = $urandom_range(1, 16);
            if (burst_left > 0)
            begin
                out_stall <= 1'b1;
                burst_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // random sender gap after a word, with junk on the fields while valid is low
    task automatic pace();
        int gap;
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            command  <= 2'($urandom);
            position <= 8'($urandom);
            value    <= $urandom;
            repeat (gap) @(posedge clk);
        end
    endtask

    // offer one command word and hold it until the block takes it
    task automatic send_word(logic [1:0] cmd, logic [7:0] pos, logic [31:0] val);
        in_valid <= 1'b1;
        command  <= cmd;
        position <= pos;
        value    <= val;
        do
            @(posedge clk);
        while (in_stall);
        shadow.note_command(cmd, pos);
        pace();
    endtask

    // drop valid and wait until every queued result word has been checked
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (shadow.pending.size() != 0)
            @(posedge clk);
    endtask

    // one random word; grow_pct steers the mix toward inserts or deletes
    task automatic random_word(int grow_pct);
        logic [1:0]  cmd;
        logic [7:0]  pos;
        logic [31:0] val;
        int          roll;
        roll = $urandom_range(0, 7);
        val = (roll == 0) ? 32'h8000_0000 :
              (roll == 1) ? 32'h7fff_ffff :
              (roll == 2) ? 32'h0000_0000 :
              (roll == 3) ? 32'hffff_ffff : $urandom;
        roll = $urandom_range(0, 99);
        if (roll < grow_pct)
            cmd = $urandom_range(0, 1) ? idll_pkg::CMD_APPEND : idll_pkg::CMD_INSERT;
        else if (roll < 96)
            cmd = idll_pkg::CMD_DELETE;
        else
            cmd = CMD_UNKNOWN;
        roll = $urandom_range(0, 9);
        case (cmd)
            // front, a live slot, or now and then any slot at all
            idll_pkg::CMD_INSERT:
                pos = (roll < 3) ? 8'd0 : (roll < 9) ? shadow.pick_live() : 8'($urandom);
            // mostly live slots; sentinel when empty, otherwise any slot
            idll_pkg::CMD_DELETE:
                pos = (roll < 8) ? shadow.pick_live() : 8'($urandom);
            default:
                pos = 8'($urandom);
        endcase
        send_word(cmd, pos, val);
    endtask

    initial
    begin
        // reset held low from time zero and released at an edge; the block then runs
        // its clearing pass with in_stall high
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: error cases on an empty list
        send_word(idll_pkg::CMD_DELETE, 8'd0, 32'd0);              // sentinel
        send_word(idll_pkg::CMD_DELETE, 8'd255, 32'd1);            // highest slot, unused
        send_word(idll_pkg::CMD_INSERT, 8'd7, 32'd2);              // after an unused slot
        // build a few elements, value extremes along the way
        send_word(idll_pkg::CMD_APPEND, 8'd200, 32'h7fff_ffff);    // position ignored
        send_word(idll_pkg::CMD_INSERT, 8'd0, 32'h8000_0000);      // at the front
        send_word(idll_pkg::CMD_INSERT, shadow.nxt[0], 32'h0);     // after a live slot
        send_word(idll_pkg::CMD_APPEND, 8'hff, 32'hffff_ffff);
        send_word(idll_pkg::CMD_INSERT, shadow.prv[0], 32'h5555_aaaa); // after the tail
        // bad positions and the unknown command on a non-empty list
        send_word(CMD_UNKNOWN, 8'd1, 32'd3);
        send_word(CMD_UNKNOWN, 8'd0, 32'd4);
        send_word(idll_pkg::CMD_INSERT, 8'd255, 32'd5);
        send_word(idll_pkg::CMD_DELETE, 8'd0, 32'd6);
        // unlink head, tail and a middle element; then delete a freed slot again
        send_word(idll_pkg::CMD_DELETE, shadow.nxt[0], 32'd7);
        send_word(idll_pkg::CMD_DELETE, shadow.prv[0], 32'd8);
        send_word(idll_pkg::CMD_DELETE, shadow.nxt[shadow.nxt[0]], 32'd9);
        send_word(idll_pkg::CMD_DELETE, shadow.free_top, 32'd10);
        // empty the list from the head, then reuse the free chain
        while (shadow.n_elems != 8'd0)
            send_word(idll_pkg::CMD_DELETE, shadow.nxt[0], 32'd11);
        send_word(idll_pkg::CMD_APPEND, 8'd0, 32'h1234_5678);
        send_word(idll_pkg::CMD_INSERT, shadow.nxt[0], 32'h8765_4321);

        // grow until the pool is full and keep pushing into it
        repeat (400) random_word(90);

        // sender pauses until every result word is back
        drain();

        // long receiver hold-off while the sender keeps offering words
        hold_request = 1'b1;
        repeat (450) random_word(5);     // shrink to empty and past it
        repeat (650) random_word(50);

        // last stretch with no idling on either side
        quiet = 1'b1;
        repeat (300) random_word(50);

        drain();
        repeat (10) @(posedge clk);
        if (shadow.errors == 0 && shadow.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
